FILE: design/dtus_pkg.sv
// Package: shared types, constants and vendor id helper for the device table.
`timescale 1ns / 1ps
package dtus_pkg;

    localparam int DEPTH_DEFAULT = 32;
    localparam int MAX_DUMP      = 32;

    localparam logic [1:0] ACT_REPORT   = 2'd0;
    localparam logic [1:0] ACT_SORT     = 2'd1;
    localparam logic [1:0] ACT_CLEAR    = 2'd2;
    localparam logic [1:0] ACT_RESERVED = 2'd3;

    localparam logic KIND_ACK   = 1'b0;
    localparam logic KIND_ENTRY = 1'b1;

    typedef struct packed {
        logic [47:0] address;
        logic [7:0]  strength;
        logic [1:0]  kind;
        logic [7:0]  services;
        logic        has_maker;
        logic [15:0] vendor;
    } entry_t;

    function automatic logic [15:0] vendor_id(input logic has, input logic [7:0] len,
                                              input logic [7:0] b0, input logic [7:0] b1);
        logic [15:0] v;
        v = 16'd0;
        if (has && (len >= 8'd2))
        begin
            v = {b1, b0};
        end
        return v;
    endfunction

endpackage

FILE: design/dtus_table.sv
// Entry memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module dtus_table #(
    parameter int TABLE_DEPTH = dtus_pkg::DEPTH_DEFAULT,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  dtus_pkg::entry_t  wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output dtus_pkg::entry_t  rd_data
);

    dtus_pkg::entry_t mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: design/device_table_upsert_sort.sv
// Top level: advertiser table with upsert, stable sort and clear.
//
// Input channel (in_valid / in_stall) takes one item at a time: a report,
// a sort-and-dump or a clear. in_stall stays high from acceptance until the
// last result of that item has been taken on the output channel.
// Output channel (out_valid / out_stall) carries result items from an
// output register; a stalled result holds until taken.
// Report: the slots are read one per cycle from the entry memory until
// the address matches or every stored slot has been read.
// Action code 3 is dropped with no result.
// Sort: in-place insertion sort on the entry memory, one element
// compare per cycle, then each entry is read and emitted in turn; at most
// 32 entries are emitted, and an empty table gives no result.
// Reset clears the entry count; the memory holds no reset and is never
// read above the count.
`timescale 1ns / 1ps
module device_table_upsert_sort #(
    parameter int TABLE_DEPTH = dtus_pkg::DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [47:0] device_address,
    input  logic signed [7:0] signal_strength,
    input  logic [1:0]  address_kind,
    input  logic [7:0]  services_seen,
    input  logic        has_maker_data,
    input  logic [7:0]  maker_data_length,
    input  logic [7:0]  maker_byte_zero,
    input  logic [7:0]  maker_byte_one,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [4:0]  slot_index,
    output logic        is_new,
    output logic        dropped,
    output logic [47:0] entry_address,
    output logic signed [7:0] entry_strength,
    output logic [1:0]  entry_kind,
    output logic [7:0]  entry_services,
    output logic        entry_has_maker,
    output logic [15:0] entry_vendor,
    output logic [5:0]  table_count,
    output logic        last
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_SEARCH = 10'b0000000010,
        S_WRITE  = 10'b0000000100,
        S_LOAD   = 10'b0000001000,
        S_KEY    = 10'b0000010000,
        S_CMP    = 10'b0000100000,
        S_PUT    = 10'b0001000000,
        S_DRD    = 10'b0010000000,
        S_DOUT   = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [AW-1:0] rdaddr_reg, rdaddr_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] j_reg, j_next;
    logic          dump_reg, dump_next;
    logic          hit_reg, hit_next;
    logic [AW-1:0] idx_reg, idx_next;
    dtus_pkg::entry_t new_reg, new_next;
    dtus_pkg::entry_t key_reg, key_next;

    logic          ov_reg, ov_next;
    logic          okind_reg, okind_next;
    logic [4:0]    oslot_reg, oslot_next;
    logic          onew_reg, onew_next;
    logic          odrop_reg, odrop_next;
    dtus_pkg::entry_t oent_reg, oent_next;
    logic [5:0]    ocnt_reg, ocnt_next;
    logic          olast_reg, olast_next;

    logic             wr_en, rd_en;
    logic [AW-1:0]    wr_addr, rd_addr;
    dtus_pkg::entry_t wr_data, rd_data;
    int               dump_n;

    dtus_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign dump_n   = (int'(count_reg) > dtus_pkg::MAX_DUMP) ? dtus_pkg::MAX_DUMP
                                                             : int'(count_reg);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        rdaddr_next = rdaddr_reg;
        pend_next   = 1'b0;
        j_next      = j_reg;
        dump_next   = dump_reg;
        hit_next    = hit_reg;
        idx_next    = idx_reg;
        new_next    = new_reg;
        key_next    = key_reg;
        ov_next     = ov_reg;
        okind_next  = okind_reg;
        oslot_next  = oslot_reg;
        onew_next   = onew_reg;
        odrop_next  = odrop_reg;
        oent_next   = oent_reg;
        ocnt_next   = ocnt_reg;
        olast_next  = olast_reg;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = new_reg;
        rd_en       = 1'b0;
        rd_addr     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    new_next.address   = device_address;
                    new_next.strength  = signal_strength;
                    new_next.kind      = address_kind;
                    new_next.services  = services_seen;
                    new_next.has_maker = has_maker_data;
                    new_next.vendor    = dtus_pkg::vendor_id(has_maker_data,
                        maker_data_length, maker_byte_zero, maker_byte_one);
                    unique case (action)
                        dtus_pkg::ACT_REPORT:
                        begin
                            ptr_next   = '0;
                            state_next = S_SEARCH;
                        end
                        dtus_pkg::ACT_SORT:
                        begin
                            ptr_next   = CW'(1);
                            state_next = (count_reg > CW'(1)) ? S_LOAD : S_DRD;
                            j_next     = '0;
                            if (count_reg == '0)
                            begin
                                state_next = S_IDLE;
                            end
                        end
                        dtus_pkg::ACT_CLEAR:
                        begin
                            count_next = '0;
                            ov_next    = 1'b1;
                            okind_next = dtus_pkg::KIND_ACK;
                            oslot_next = '0;
                            onew_next  = 1'b0;
                            odrop_next = 1'b0;
                            oent_next  = '0;
                            ocnt_next  = '0;
                            olast_next = 1'b1;
                            dump_next  = 1'b0;
                            state_next = S_OUT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (pend_reg && (rd_data.address == new_reg.address))
                begin
                    hit_next   = 1'b1;
                    idx_next   = rdaddr_reg;
                    state_next = S_WRITE;
                end
                else if (ptr_reg < count_reg)
                begin
                    rd_en       = 1'b1;
                    rd_addr     = ptr_reg[AW-1:0];
                    rdaddr_next = ptr_reg[AW-1:0];
                    ptr_next    = ptr_reg + CW'(1);
                    pend_next   = 1'b1;
                end
                else if (!pend_reg)
                begin
                    hit_next   = 1'b0;
                    idx_next   = count_reg[AW-1:0];
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                ov_next    = 1'b1;
                okind_next = dtus_pkg::KIND_ACK;
                olast_next = 1'b1;
                dump_next  = 1'b0;
                state_next = S_OUT;
                if (!hit_reg && (int'(count_reg) >= TABLE_DEPTH))
                begin
                    oslot_next = '0;
                    onew_next  = 1'b0;
                    odrop_next = 1'b1;
                    oent_next  = '0;
                    ocnt_next  = 6'(count_reg);
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = idx_reg;
                    wr_data    = new_reg;
                    oslot_next = 5'(idx_reg);
                    onew_next  = !hit_reg;
                    odrop_next = 1'b0;
                    oent_next  = new_reg;
                    if (!hit_reg)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    ocnt_next  = 6'(hit_reg ? count_reg : count_reg + CW'(1));
                end
            end
            S_LOAD:
            begin
                rd_en      = 1'b1;
                rd_addr    = ptr_reg[AW-1:0];
                j_next     = ptr_reg[AW-1:0];
                state_next = S_KEY;
            end
            S_KEY:
            begin
                key_next   = rd_data;
                rd_en      = 1'b1;
                rd_addr    = j_reg - AW'(1);
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if ($signed(rd_data.strength) < $signed(key_reg.strength))
                begin
                    // shift the smaller entry up one slot
                    wr_en   = 1'b1;
                    wr_addr = j_reg;
                    wr_data = rd_data;
                    j_next  = j_reg - AW'(1);
                    if (j_reg == AW'(1))
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = j_reg - AW'(2);
                    end
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                wr_en    = 1'b1;
                wr_addr  = j_reg;
                wr_data  = key_reg;
                ptr_next = ptr_reg + CW'(1);
                if ((ptr_reg + CW'(1)) < count_reg)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    j_next     = '0;
                    state_next = S_DRD;
                end
            end
            S_DRD:
            begin
                rd_en      = 1'b1;
                rd_addr    = j_reg;
                state_next = S_DOUT;
            end
            S_DOUT:
            begin
                ov_next    = 1'b1;
                okind_next = dtus_pkg::KIND_ENTRY;
                oslot_next = 5'(j_reg);
                onew_next  = 1'b0;
                odrop_next = 1'b0;
                oent_next  = rd_data;
                ocnt_next  = 6'(count_reg);
                olast_next = (int'(j_reg) + 1 == dump_n);
                dump_next  = (int'(j_reg) + 1 != dump_n);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    ov_next = 1'b0;
                    if (dump_reg)
                    begin
                        j_next     = j_reg + AW'(1);
                        state_next = S_DRD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            dump_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            ov_reg    <= ov_next;
            dump_reg  <= dump_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        rdaddr_reg <= rdaddr_next;
        j_reg      <= j_next;
        hit_reg    <= hit_next;
        idx_reg    <= idx_next;
        new_reg    <= new_next;
        key_reg    <= key_next;
        okind_reg  <= okind_next;
        oslot_reg  <= oslot_next;
        onew_reg   <= onew_next;
        odrop_reg  <= odrop_next;
        oent_reg   <= oent_next;
        ocnt_reg   <= ocnt_next;
        olast_reg  <= olast_next;
    end

    assign out_valid       = ov_reg;
    assign result_kind     = okind_reg;
    assign slot_index      = oslot_reg;
    assign is_new          = onew_reg;
    assign dropped         = odrop_reg;
    assign entry_address   = oent_reg.address;
    assign entry_strength  = oent_reg.strength;
    assign entry_kind      = oent_reg.kind;
    assign entry_services  = oent_reg.services;
    assign entry_has_maker = oent_reg.has_maker;
    assign entry_vendor    = oent_reg.vendor;
    assign table_count     = ocnt_reg;
    assign last            = olast_reg;

endmodule

FILE: design/dtus_checker.sv
// Port checker for the device table, bound to the top level.
`timescale 1ns / 1ps
module dtus_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        result_kind,
    input logic        is_new,
    input logic        dropped,
    input logic [47:0] entry_address,
    input logic        last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(entry_address))
        else $error("stalled item changed");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");

    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dropped |-> !is_new && last && (result_kind == dtus_pkg::KIND_ACK))
        else $error("bad drop acknowledgement");

    a_entry: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == dtus_pkg::KIND_ENTRY) |-> !is_new && !dropped)
        else $error("bad sorted entry flags");

endmodule

bind device_table_upsert_sort dtus_checker u_dtus_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .is_new        (is_new),
    .dropped       (dropped),
    .entry_address (entry_address),
    .last          (last)
);
